// ===== rtl/lcc_pkg.sv =====
// Shared types, constants and the code table of the line printer code converter.
// No dependencies; used by every module in rtl/.
package lcc_pkg;

   localparam int LINE_LIMIT_BYTES = 256;
   localparam int LANES            = 6;
   localparam int BYTE_W           = 8;
   localparam int CP_W             = 16;
   localparam int LBC_W            = $clog2(LINE_LIMIT_BYTES + 1);
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [BYTE_W-1:0] BLANK_CODE  = 8'h40;
   localparam logic [BYTE_W-1:0] LOAD_CODE_A = 8'h63;
   localparam logic [BYTE_W-1:0] LOAD_CODE_B = 8'hFB;
   localparam logic [BYTE_W-1:0] RUN_MAX     = 8'hFF;
   localparam logic [CP_W-1:0]   SUBST_CP    = 16'h00B7;
   localparam logic [1:0]        OP_PRINT    = 2'b01;
   localparam int                OP_FF_BIT   = 7;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   // word index of a register: paddr[2]
   localparam logic REG_PRINTER_READY = 1'b0;

   typedef enum logic [2:0] {
      KIND_CHAR       = 3'd0,
      KIND_SPACE_RUN  = 3'd1,
      KIND_LINE_FEED  = 3'd2,
      KIND_CR         = 3'd3,
      KIND_FORM_FEED  = 3'd4,
      KIND_DONE       = 3'd5
   } kind_type;

   typedef struct packed {
      logic            blank;
      logic [CP_W-1:0] cp;
   } lane_type;

   typedef struct packed {
      logic                    cmd;
      logic [BYTE_W-1:0]       op;
      lane_type [LANES-1:0]    lanes;
   } stage_type;

   typedef struct packed {
      kind_type          kind;
      logic [CP_W-1:0]   cp;
      logic [BYTE_W-1:0] run;
      logic              status;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pending;
      logic [LBC_W-1:0]  count;
   } line_state_type;

   function automatic logic [CP_W-1:0] code_map(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] cp;
      case (b)
         8'h40: cp = 16'h0020;
         8'h4A: cp = 16'h005B;
         8'h4B: cp = 16'h002E;
         8'h4C: cp = 16'h003C;
         8'h4D: cp = 16'h0028;
         8'h4E: cp = 16'h002B;
         8'h4F: cp = 16'h007C;
         8'h50: cp = 16'h0026;
         8'h5A: cp = 16'h005D;
         8'h5B: cp = 16'h00A4;
         8'h5C: cp = 16'h002A;
         8'h5D: cp = 16'h0029;
         8'h5E: cp = 16'h003B;
         8'h5F: cp = 16'h00AC;
         8'h60: cp = 16'h002D;
         8'h61: cp = 16'h002F;
         8'h6A: cp = 16'h00A6;
         8'h6B: cp = 16'h002C;
         8'h6C: cp = 16'h0025;
         8'h6D: cp = 16'h005F;
         8'h6E: cp = 16'h003E;
         8'h6F: cp = 16'h003F;
         8'h7A: cp = 16'h003A;
         8'h7B: cp = 16'h0023;
         8'h7C: cp = 16'h0040;
         8'h7D: cp = 16'h0027;
         8'h7E: cp = 16'h003D;
         8'h7F: cp = 16'h0022;
         8'hB8: cp = 16'h042E;
         8'hBA: cp = 16'h0411;
         8'hBB: cp = 16'h0426;
         8'hBC: cp = 16'h0414;
         8'hBE: cp = 16'h0424;
         8'hBF: cp = 16'h0413;
         8'hC1: cp = 16'h0410;
         8'hC2: cp = 16'h0412;
         8'hC3: cp = 16'h0421;
         8'hC4: cp = 16'h0044;
         8'hC5: cp = 16'h0415;
         8'hC6: cp = 16'h0046;
         8'hC7: cp = 16'h0047;
         8'hC8: cp = 16'h041D;
         8'hC9: cp = 16'h0049;
         8'hCB: cp = 16'h0418;
         8'hCC: cp = 16'h0419;
         8'hCE: cp = 16'h041B;
         8'hD1: cp = 16'h004A;
         8'hD2: cp = 16'h041A;
         8'hD3: cp = 16'h004C;
         8'hD4: cp = 16'h041C;
         8'hD5: cp = 16'h004E;
         8'hD6: cp = 16'h041E;
         8'hD7: cp = 16'h0420;
         8'hD8: cp = 16'h0051;
         8'hD9: cp = 16'h0052;
         8'hDC: cp = 16'h041F;
         8'hDD: cp = 16'h042F;
         8'hE2: cp = 16'h0053;
         8'hE3: cp = 16'h0422;
         8'hE4: cp = 16'h0055;
         8'hE5: cp = 16'h0056;
         8'hE6: cp = 16'h0057;
         8'hE7: cp = 16'h0425;
         8'hE8: cp = 16'h0059;
         8'hE9: cp = 16'h005A;
         8'hEB: cp = 16'h0423;
         8'hEC: cp = 16'h0416;
         8'hEE: cp = 16'h042C;
         8'hEF: cp = 16'h042B;
         8'hF0: cp = 16'h0030;
         8'hF1: cp = 16'h0031;
         8'hF2: cp = 16'h0032;
         8'hF3: cp = 16'h0033;
         8'hF4: cp = 16'h0034;
         8'hF5: cp = 16'h0035;
         8'hF6: cp = 16'h0036;
         8'hF7: cp = 16'h0037;
         8'hF8: cp = 16'h0038;
         8'hF9: cp = 16'h0039;
         8'hFA: cp = 16'h0417;
         8'hFB: cp = 16'h0428;
         8'hFC: cp = 16'h042D;
         8'hFD: cp = 16'h0429;
         8'hFE: cp = 16'h0427;
         8'hFF: cp = 16'h042A;
         default: cp = SUBST_CP;
      endcase
      return cp;
   endfunction

endpackage

// ===== rtl/line_printer_code_converter.sv =====
// Line printer code converter, top level. Depends on lcc_pkg, lcc_lane, lcc_merge.
// Flow: an accepted item waits in the stage-1 register until the result buffer is
//   empty, then is merged into that buffer, from which its first result is offered.
// Throughput: one item per cycle when each gives at most one result and rsp_stall is
//   low; a data word with n printable bytes (up to 6) holds the result buffer until
//   the single result port, draining one slot per cycle when not stalled, empties it.
// Reset (synchronous): clears printer_ready, blank count, byte count and all valids.
module line_printer_code_converter
   import lcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [BYTE_W-1:0]     req_op_code,
   input  logic [LANES*BYTE_W-1:0] req_data_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_kind,
   output logic [CP_W-1:0]       rsp_code_point,
   output logic [BYTE_W-1:0]     rsp_run_length,
   output logic                  rsp_status,
   output logic                  rsp_last_of_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic                   ready_ff, ready_in;
   logic                   s1_valid_ff, s1_valid_in;
   stage_type              s1_item_ff, s1_item_in;
   line_state_type         state_ff, state_in;
   logic [LANES-1:0]       buf_mask_ff, buf_mask_in;
   result_type [LANES-1:0] buf_slots_ff, buf_slots_in;

   lane_type [LANES-1:0]   lanes;
   result_type [LANES-1:0] merge_slots;
   logic [LANES-1:0]       merge_mask;
   line_state_type         merge_state;

   logic [LANES-1:0]       sel;
   logic [LANES-1:0]       mask_after;
   result_type             pick;
   logic                   take, load, accept, csr_write;

   // register interface
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_PRINTER_READY) ?
                       {{(CSR_DATA_W-1){1'b0}}, ready_ff} : '0;
   assign ready_in   = (csr_write && csr_paddr[2] == REG_PRINTER_READY) ?
                       csr_pwdata[0] : ready_ff;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      lcc_lane u_lane (
         .code_byte (req_data_word[(LANES-g)*BYTE_W-1 -: BYTE_W]),
         .lane      (lanes[g])
      );
   end

   lcc_merge u_merge (
      .item          (s1_item_ff),
      .line_state    (state_ff),
      .printer_ready (ready_ff),
      .slots         (merge_slots),
      .slot_mask     (merge_mask),
      .next_state    (merge_state)
   );

   // drain: lowest pending slot goes out first
   assign sel = buf_mask_ff & (~buf_mask_ff + LANES'(1));

   always_comb begin
      pick = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (buf_mask_ff[i]) begin
            pick = buf_slots_ff[i];
         end
      end
   end

   assign rsp_valid        = |buf_mask_ff;
   assign rsp_kind         = pick.kind;
   assign rsp_code_point   = pick.cp;
   assign rsp_run_length   = pick.run;
   assign rsp_status       = pick.status;
   assign rsp_last_of_item = ((buf_mask_ff & ~sel) == '0);

   assign take       = rsp_valid && !rsp_stall;
   assign mask_after = take ? (buf_mask_ff & ~sel) : buf_mask_ff;
   assign load       = s1_valid_ff && (mask_after == '0);
   assign req_stall  = s1_valid_ff && !load;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !load);
      s1_item_in  = s1_item_ff;
      if (accept) begin
         s1_item_in.cmd   = req_cmd;
         s1_item_in.op    = req_op_code;
         s1_item_in.lanes = lanes;
      end
      buf_mask_in  = load ? merge_mask  : mask_after;
      buf_slots_in = load ? merge_slots : buf_slots_ff;
      state_in     = load ? merge_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         state_ff    <= '0;
         buf_mask_ff <= '0;
      end else begin
         ready_ff    <= ready_in;
         s1_valid_ff <= s1_valid_in;
         state_ff    <= state_in;
         buf_mask_ff <= buf_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      buf_slots_ff <= buf_slots_in;
   end

endmodule

// ===== rtl/lcc_lane.sv =====
// One byte lane: classifies a code byte and maps it to its code point.
// Depends on lcc_pkg (code table, lane_type).
module lcc_lane
   import lcc_pkg::*;
(
   input  logic [BYTE_W-1:0] code_byte,
   output lane_type          lane
);

   assign lane.blank = (code_byte == BLANK_CODE);
   assign lane.cp    = code_map(code_byte);

endmodule

// ===== rtl/lcc_merge.sv =====
// Merge stage: folds the six lane results with the blank count into result slots,
// and works out the carriage action of an end item. Depends on lcc_pkg.
module lcc_merge
   import lcc_pkg::*;
(
   input  stage_type                item,
   input  line_state_type           line_state,
   input  logic                     printer_ready,
   output result_type [LANES-1:0]   slots,
   output logic [LANES-1:0]         slot_mask,
   output line_state_type           next_state
);

   always_comb begin
      logic [BYTE_W-1:0] acc;
      logic [LBC_W:0]    sum;
      logic [1:0]        feeds;

      slots      = '0;
      slot_mask  = '0;
      next_state = line_state;
      acc        = line_state.pending;
      sum        = {1'b0, line_state.count} + (LBC_W+1)'(LANES);
      feeds      = item.op[4:3];

      if (!item.cmd) begin
         if (printer_ready && item.op[1:0] == OP_PRINT &&
             sum <= (LBC_W+1)'(LINE_LIMIT_BYTES)) begin
            for (int i = 0; i < LANES; i++) begin
               if (item.lanes[i].blank) begin
                  if (acc != RUN_MAX) begin
                     acc = acc + 8'd1;
                  end
               end else begin
                  // blanks before a printable byte ride along with it
                  slots[i].kind   = (acc != '0) ? KIND_SPACE_RUN : KIND_CHAR;
                  slots[i].cp     = item.lanes[i].cp;
                  slots[i].run    = acc;
                  slots[i].status = STATUS_OK;
                  slot_mask[i]    = 1'b1;
                  acc             = '0;
               end
            end
            next_state.pending = acc;
            next_state.count   = sum[LBC_W-1:0];
         end
      end else begin
         next_state   = '0;
         slot_mask[0] = 1'b1;
         if (!printer_ready) begin
            slots[0].kind   = KIND_DONE;
            slots[0].status = STATUS_NOT_READY;
         end else if (!item.op[0] || item.op == LOAD_CODE_A || item.op == LOAD_CODE_B) begin
            slots[0].kind = KIND_DONE;
         end else if (item.op[OP_FF_BIT]) begin
            slots[0].kind = KIND_FORM_FEED;
         end else if (feeds != 2'd0) begin
            slots[0].kind = KIND_LINE_FEED;
            slots[0].run  = {6'd0, feeds};
         end else if (item.op[1:0] == OP_PRINT) begin
            slots[0].kind = KIND_CR;
         end else begin
            slots[0].kind = KIND_DONE;
         end
      end
   end

endmodule

// ===== tb/line_printer_code_converter_tb.sv =====
// Self-checking testbench for line_printer_code_converter: directed and random print
// requests with a predictor of the printed output. Depends on lcc_pkg and the RTL top.
module line_printer_code_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int LINE_WORDS     = LINE_LIMIT_BYTES / LANES;

   // channel command bytes used by the directed tests
   localparam logic [7:0] OP_PRINT_CR  = 8'h01;
   localparam logic [7:0] OP_PRINT_LF1 = 8'h09;
   localparam logic [7:0] OP_PRINT_LF2 = 8'h11;
   localparam logic [7:0] OP_PRINT_LF3 = 8'h19;
   localparam logic [7:0] OP_PRINT_FF  = 8'h81;
   localparam logic [7:0] OP_CTRL_NOP  = 8'h03;
   localparam logic [7:0] OP_CTRL_LF   = 8'h0B;
   localparam logic [7:0] OP_CTRL_FF   = 8'hFF;
   localparam logic [7:0] OP_SENSE     = 8'h00;
   localparam logic [7:0] OP_READ      = 8'h02;

   typedef struct {
      kind_type          kind;
      logic [CP_W-1:0]   cp;
      logic [BYTE_W-1:0] run;
      logic              status;
      logic              last;
   } print_out_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_cmd;
   logic [BYTE_W-1:0]       req_op_code;
   logic [LANES*BYTE_W-1:0] req_data_word;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [2:0]              rsp_kind;
   logic [CP_W-1:0]         rsp_code_point;
   logic [BYTE_W-1:0]       rsp_run_length;
   logic                    rsp_status;
   logic                    rsp_last_of_item;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // predictor state
   print_out_type     printer_output_q[$];
   logic              model_ready;
   logic [BYTE_W-1:0] blank_run;
   int                line_fill;

   int errors;
   int burst_left;
   int idle_cycles;
   int stall_seg_left;
   int stall_mode;
   int stall_phase;

   line_printer_code_converter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_op_code      (req_op_code),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_code_point   (rsp_code_point),
      .rsp_run_length   (rsp_run_length),
      .rsp_status       (rsp_status),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [CP_W-1:0] map_code_point(input logic [7:0] code);
      case (code)
         8'h4A: return 16'h005B;  8'h4B: return 16'h002E;  8'h4C: return 16'h003C;
         8'h4D: return 16'h0028;  8'h4E: return 16'h002B;  8'h4F: return 16'h007C;
         8'h50: return 16'h0026;  8'h5A: return 16'h005D;  8'h5B: return 16'h00A4;
         8'h5C: return 16'h002A;  8'h5D: return 16'h0029;  8'h5E: return 16'h003B;
         8'h5F: return 16'h00AC;  8'h60: return 16'h002D;  8'h61: return 16'h002F;
         8'h6A: return 16'h00A6;  8'h6B: return 16'h002C;  8'h6C: return 16'h0025;
         8'h6D: return 16'h005F;  8'h6E: return 16'h003E;  8'h6F: return 16'h003F;
         8'h7A: return 16'h003A;  8'h7B: return 16'h0023;  8'h7C: return 16'h0040;
         8'h7D: return 16'h0027;  8'h7E: return 16'h003D;  8'h7F: return 16'h0022;
         8'hB8: return 16'h042E;  8'hBA: return 16'h0411;  8'hBB: return 16'h0426;
         8'hBC: return 16'h0414;  8'hBE: return 16'h0424;  8'hBF: return 16'h0413;
         8'hC1: return 16'h0410;  8'hC2: return 16'h0412;  8'hC3: return 16'h0421;
         8'hC4: return 16'h0044;  8'hC5: return 16'h0415;  8'hC6: return 16'h0046;
         8'hC7: return 16'h0047;  8'hC8: return 16'h041D;  8'hC9: return 16'h0049;
         8'hCB: return 16'h0418;  8'hCC: return 16'h0419;  8'hCE: return 16'h041B;
         8'hD1: return 16'h004A;  8'hD2: return 16'h041A;  8'hD3: return 16'h004C;
         8'hD4: return 16'h041C;  8'hD5: return 16'h004E;  8'hD6: return 16'h041E;
         8'hD7: return 16'h0420;  8'hD8: return 16'h0051;  8'hD9: return 16'h0052;
         8'hDC: return 16'h041F;  8'hDD: return 16'h042F;  8'hE2: return 16'h0053;
         8'hE3: return 16'h0422;  8'hE4: return 16'h0055;  8'hE5: return 16'h0056;
         8'hE6: return 16'h0057;  8'hE7: return 16'h0425;  8'hE8: return 16'h0059;
         8'hE9: return 16'h005A;  8'hEB: return 16'h0423;  8'hEC: return 16'h0416;
         8'hEE: return 16'h042C;  8'hEF: return 16'h042B;  8'hF0: return 16'h0030;
         8'hF1: return 16'h0031;  8'hF2: return 16'h0032;  8'hF3: return 16'h0033;
         8'hF4: return 16'h0034;  8'hF5: return 16'h0035;  8'hF6: return 16'h0036;
         8'hF7: return 16'h0037;  8'hF8: return 16'h0038;  8'hF9: return 16'h0039;
         8'hFA: return 16'h0417;  8'hFB: return 16'h0428;  8'hFC: return 16'h042D;
         8'hFD: return 16'h0429;  8'hFE: return 16'h0427;  8'hFF: return 16'h042A;
         default: return SUBST_CP;
      endcase
   endfunction

   task automatic predict_printer_output(input logic cmd, input logic [7:0] op,
                                         input logic [47:0] word);
      print_out_type r;
      logic [7:0]    code;
      int            n;
      n = 0;
      r.cp     = '0;
      r.run    = '0;
      r.status = STATUS_OK;
      r.last   = 1'b0;
      if (!cmd) begin
         if (!model_ready || op[1:0] != OP_PRINT) return;
         if (line_fill + LANES > LINE_LIMIT_BYTES) return;
         line_fill += LANES;
         for (int k = LANES - 1; k >= 0; k--) begin
            code = word[8*k +: 8];
            if (code == BLANK_CODE) begin
               if (blank_run != RUN_MAX) blank_run++;
               continue;
            end
            r.kind = (blank_run != 0) ? KIND_SPACE_RUN : KIND_CHAR;
            r.cp   = map_code_point(code);
            r.run  = blank_run;
            printer_output_q.push_back(r);
            blank_run = '0;
            n++;
         end
         if (n > 0) printer_output_q[$].last = 1'b1;
         return;
      end
      // end of request: pending blanks are dropped, then the carriage action
      blank_run = '0;
      line_fill = 0;
      r.last    = 1'b1;
      if (!model_ready) begin
         r.kind   = KIND_DONE;
         r.status = STATUS_NOT_READY;
      end else if (!op[0] || op == LOAD_CODE_A || op == LOAD_CODE_B) begin
         r.kind = KIND_DONE;
      end else if (op[OP_FF_BIT]) begin
         r.kind = KIND_FORM_FEED;
      end else if (op[4:3] != 2'b00) begin
         r.kind = KIND_LINE_FEED;
         r.run  = {6'd0, op[4:3]};
      end else if (op[1:0] == OP_PRINT) begin
         r.kind = KIND_CR;
      end else begin
         r.kind = KIND_DONE;
      end
      printer_output_q.push_back(r);
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   // one monitor for both channels and the register port, sampled at the edge
   always @(posedge clock) begin
      print_out_type want;
      if (reset) begin
         model_ready = 1'b0;
         blank_run   = '0;
         line_fill   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (printer_output_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual kind %0d cp 0x%0h",
                        $time, rsp_kind, rsp_code_point);
            end else begin
               want = printer_output_q.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("code_point", want.cp, rsp_code_point);
               check_field("run_length", want.run, rsp_run_length);
               check_field("status", want.status, rsp_status);
               check_field("last_of_item", want.last, rsp_last_of_item);
            end
         end
         if (req_valid && !req_stall)
            predict_printer_output(req_cmd, req_op_code, req_data_word);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) model_ready = csr_pwdata[0];
            else check_field("prdata", model_ready, csr_prdata);
         end
      end
   end

   // result side back-pressure: segments of free flow, random, heavy and periodic stall
   always @(posedge clock) begin
      if (stall_seg_left == 0) begin
         stall_seg_left = $urandom_range(8, 64);
         stall_mode     = $urandom_range(0, 3);
      end else begin
         stall_seg_left--;
      end
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         2: rsp_stall <= ($urandom_range(0, 4) != 0);
         default: rsp_stall <= (stall_phase % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic [47:0] random_bits48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return BLANK_CODE;
         4, 5, 6:    return 8'($urandom_range(8'hB8, 8'hFF));
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [47:0] random_line_word();
      logic [47:0] word;
      if ($urandom_range(0, 7) == 0) return random_bits48();
      for (int k = 0; k < LANES; k++) word[8*k +: 8] = pick_code();
      return word;
   endfunction

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_item(input logic cmd, input logic [7:0] op, input logic [47:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_op_code   <= op;
      req_data_word <= word;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // hold off until every expected result has come, then let in-flight items settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (printer_output_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {REG_PRINTER_READY, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // write printer_ready and read it back
   task automatic set_ready(input logic value);
      csr_access(1'b1, {31'b0, value});
      csr_access(1'b0, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_not_ready();
      send_item(1'b0, OP_PRINT_CR, 48'hC1C2C3C4C5C6);
      send_item(1'b1, OP_PRINT_CR, 48'h0);
      send_item(1'b1, OP_CTRL_FF, '1);
      drain_results();
   endtask

   task automatic test_ready_register();
      set_ready(1'b1);
      set_ready(1'b0);
      set_ready(1'b1);
   endtask

   task automatic test_print_directed();
      logic [7:0] feed_ops [4] = '{OP_PRINT_LF1, OP_PRINT_LF2, OP_PRINT_LF3, OP_PRINT_FF};
      logic [7:0] end_ops [6]  = '{OP_CTRL_LF, OP_CTRL_FF, OP_SENSE, OP_READ,
                                   LOAD_CODE_A, LOAD_CODE_B};
      send_item(1'b0, OP_PRINT_CR, 48'h000000000000);
      send_item(1'b0, OP_PRINT_CR, 48'hFFFFFFFFFFFF);
      send_item(1'b0, OP_PRINT_CR, 48'h4040C1404040);
      // this word's leading blanks join the run carried over from the previous word
      send_item(1'b0, OP_PRINT_CR, 48'h4040404040B8);
      send_item(1'b0, OP_PRINT_CR, 48'h404040404040);
      send_item(1'b1, OP_PRINT_CR, random_bits48());
      send_item(1'b0, OP_CTRL_NOP, 48'hF1F2F3F4F5F6);
      send_item(1'b1, OP_CTRL_NOP, 48'h0);
      foreach (feed_ops[i]) begin
         send_item(1'b0, feed_ops[i], 48'h40C4C9C6C6C1);
         send_item(1'b1, feed_ops[i], random_bits48());
      end
      foreach (end_ops[i]) send_item(1'b1, end_ops[i], random_bits48());
      drain_results();
   endtask

   task automatic test_line_full();
      repeat (LINE_WORDS - 1) send_item(1'b0, OP_PRINT_LF1, 48'h404040404040);
      send_item(1'b0, OP_PRINT_LF1, 48'h4040404040C1);
      send_item(1'b0, OP_PRINT_LF1, 48'hF1F2F3F4F5F6);
      send_item(1'b1, OP_PRINT_LF1, 48'h0);
      // byte count restarts with the next line
      send_item(1'b0, OP_PRINT_CR, 48'hF1F2F3F4F5F6);
      send_item(1'b1, OP_PRINT_CR, 48'h0);
      drain_results();
   endtask

   task automatic test_not_ready_midline();
      send_item(1'b0, OP_PRINT_CR, 48'hC14040404040);
      drain_results();
      set_ready(1'b0);
      send_item(1'b0, OP_PRINT_CR, 48'h40404040F1F1);
      send_item(1'b1, OP_PRINT_CR, 48'h0);
      drain_results();
      set_ready(1'b1);
      send_item(1'b0, OP_PRINT_CR, 48'h40F0F0F0F0F0);
      send_item(1'b1, OP_PRINT_CR, 48'h0);
      drain_results();
   endtask

   task automatic run_random_requests(input int target);
      int         counted;
      int         nwords;
      logic [7:0] op;
      logic       noisy;
      counted = 0;
      while (counted < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: op = {6'($urandom), OP_PRINT};
            6:                op = $urandom_range(0, 1) ? LOAD_CODE_A : LOAD_CODE_B;
            default:          op = 8'($urandom);
         endcase
         noisy  = ($urandom_range(0, 9) == 0);
         nwords = ($urandom_range(0, 15) == 0) ? $urandom_range(LINE_WORDS - 4, LINE_WORDS + 3)
                                               : $urandom_range(0, 8);
         for (int w = 0; w < nwords; w++) begin
            counted++;
            send_item(1'b0, noisy ? 8'($urandom) : op, random_line_word());
         end
         send_item(1'b1, op, random_bits48());
         counted++;
         if ($urandom_range(0, 19) == 0) drain_results();
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      run_random_requests(160);
      set_ready(1'b0);
      run_random_requests(30);
      set_ready(1'b1);
      run_random_requests(100);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = 1'b0;
      req_op_code    = '0;
      req_data_word  = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      errors         = 0;
      burst_left     = 0;
      idle_cycles    = 0;
      stall_seg_left = 0;
      stall_mode     = 0;
      stall_phase    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_not_ready();
      test_ready_register();
      test_print_directed();
      test_line_full();
      test_not_ready_midline();
      test_random_traffic();
      drain_results();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
